// ===== hw/rtl/aese_pkg.sv =====
package aese_pkg;

   // Alignment size limit and the widths that follow from it
   localparam int MAX_COLUMNS = 4096;
   localparam int COL_W       = (MAX_COLUMNS > 2) ? $clog2(MAX_COLUMNS) : 1;
   localparam logic [COL_W-1:0] INDEX_LIMIT = COL_W'(MAX_COLUMNS - 1);

   // Octal digits needed for the largest distance
   localparam int OCT_DIGITS = (COL_W + 2) / 3;
   localparam int DIST_W     = OCT_DIGITS * 3;
   localparam int DIG_W      = (OCT_DIGITS > 1) ? $clog2(OCT_DIGITS) : 1;

   // Command queue between classifier and emitter (power of two depth)
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Characters
   localparam logic [7:0] GAP_CHAR = 8'd45;   // '-'
   localparam logic [7:0] INS_CHAR = 8'd105;  // 'i'
   localparam logic [7:0] SUB_CHAR = 8'd115;  // 's'
   localparam logic [7:0] DIGIT0   = 8'd48;   // '0'

   // One mismatching column, as handed to the emitter
   typedef struct packed {
      logic              start;    // column opens a new run
      logic              is_ins;   // insertion run, else substitution/deletion
      logic [DIG_W-1:0]  top;      // index of the most significant octal digit
      logic [DIST_W-1:0] distance; // distance from the previous run start
      logic [7:0]        qc;       // query character
   } aese_cmd_type;

   // Queue head as seen by the emitter
   typedef struct packed {
      logic         valid;
      aese_cmd_type cmd;
   } aese_head_type;

   // Emitter sequence over one command
   typedef enum logic [1:0] {
      PH_HEAD,
      PH_DIGIT,
      PH_CHAR
   } aese_phase_type;

endpackage

// ===== hw/rtl/aese_front.sv =====
module aese_front import aese_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // ref_char [7:0], query_char [15:8]
   input  logic         req_tlast,   // final_column
   input  logic         queue_full,
   output logic         push_valid,
   output aese_cmd_type push_cmd
);

   logic             ins_open_ff, ins_open_in;
   logic             sub_open_ff, sub_open_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] prev_ff, prev_in;

   logic             accept;
   logic [7:0]       rc;
   logic [7:0]       qc;
   logic             is_ins;
   logic             is_match;
   logic             run_open;
   logic [COL_W-1:0] distance;
   logic [DIST_W-1:0] dist_pad;
   logic [DIG_W-1:0] top;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign rc         = req_tdata[7:0];
   assign qc         = req_tdata[15:8];
   assign is_ins     = (rc == GAP_CHAR);
   assign is_match   = (qc == rc);
   assign run_open   = is_ins ? ins_open_ff : sub_open_ff;
   assign distance   = (col_ff >= prev_ff) ? (col_ff - prev_ff) : '0;
   assign dist_pad   = DIST_W'(distance);

   // Find the leading nonzero octal digit (zero distance shows one digit)
   always_comb begin
      top = '0;
      for (int k = 1; k < OCT_DIGITS; k++) begin
         if (dist_pad[3*k +: 3] != 3'd0) begin
            top = DIG_W'(k);
         end
      end
   end

   // Build the command for a mismatching column
   always_comb begin
      push_valid        = accept && !is_match;
      push_cmd.start    = !run_open;
      push_cmd.is_ins   = is_ins;
      push_cmd.top      = top;
      push_cmd.distance = dist_pad;
      push_cmd.qc       = qc;
   end

   // Update run and column state on each transfer
   always_comb begin
      ins_open_in = ins_open_ff;
      sub_open_in = sub_open_ff;
      col_in      = col_ff;
      prev_in     = prev_ff;
      if (accept) begin
         if (is_match) begin
            ins_open_in = 1'b0;
            sub_open_in = 1'b0;
         end else begin
            ins_open_in = is_ins;
            sub_open_in = !is_ins;
            if (!run_open) begin
               prev_in = col_ff;
            end
         end
         col_in = (col_ff < INDEX_LIMIT) ? (col_ff + 1'b1) : INDEX_LIMIT;
         if (req_tlast) begin
            ins_open_in = 1'b0;
            sub_open_in = 1'b0;
            col_in      = '0;
            prev_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_open_ff <= 1'b0;
         sub_open_ff <= 1'b0;
         col_ff      <= '0;
         prev_ff     <= '0;
      end else begin
         ins_open_ff <= ins_open_in;
         sub_open_ff <= sub_open_in;
         col_ff      <= col_in;
         prev_ff     <= prev_in;
      end
   end

endmodule

// ===== hw/rtl/aese_fifo.sv =====
module aese_fifo import aese_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  aese_cmd_type  push_cmd,
   output logic          full,
   input  logic          pop,
   output aese_head_type head
);

   aese_cmd_type      mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head.valid;

   // Advance pointers and occupancy; pointers wrap at the depth
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/aese_back.sv =====
module aese_back import aese_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  aese_head_type head,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // out_char [7:0]
   output logic          rsp_tlast    // run_end
);

   aese_phase_type   phase_ff, phase_in;
   logic [DIG_W-1:0] dig_ff, dig_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_load;
   logic             emit;
   logic [2:0]       digit;

   assign out_load   = !rsp_valid_ff || rsp_tready;
   assign emit       = out_load && head.valid;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Select the current octal digit of the distance
   always_comb begin
      digit = 3'd0;
      for (int k = 0; k < OCT_DIGITS; k++) begin
         if (dig_ff == DIG_W'(k)) begin
            digit = head.cmd.distance[3*k +: 3];
         end
      end
   end

   // Step through prefix, digits and query character; continuing runs send only qc
   always_comb begin
      phase_in     = phase_ff;
      dig_in       = dig_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         case (phase_ff)
            PH_HEAD: begin
               if (head.cmd.start) begin
                  rsp_char_in = head.cmd.is_ins ? INS_CHAR : SUB_CHAR;
                  rsp_last_in = 1'b0;
                  dig_in      = head.cmd.top;
                  phase_in    = PH_DIGIT;
               end else begin
                  rsp_char_in = head.cmd.qc;
                  rsp_last_in = 1'b1;
                  pop         = 1'b1;
               end
            end
            PH_DIGIT: begin
               rsp_char_in = DIGIT0 + {5'd0, digit};
               rsp_last_in = 1'b0;
               if (dig_ff == '0) begin
                  phase_in = PH_CHAR;
               end else begin
                  dig_in = dig_ff - 1'b1;
               end
            end
            PH_CHAR: begin
               rsp_char_in = head.cmd.qc;
               rsp_last_in = 1'b1;
               pop         = 1'b1;
               phase_in    = PH_HEAD;
            end
            default: begin
               phase_in     = PH_HEAD;
               rsp_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEAD;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold output payload
   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== hw/rtl/alignment_edit_script_encoder_core.sv =====
// A column's first character passes the command queue and then the output register.
// Throughput: one column per cycle into a 4-entry command queue unless full; the emitter
// sends one character per cycle unless the output stalls; a run start sends a prefix,
// top + 1 digits, the query char (up to 6 at 4096 columns); a continuing run the query char.
// Reset: synchronous, clears run state, column counter, queue and output.
module alignment_edit_script_encoder_core import aese_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ref_char [7:0], query_char [15:8]
   input  logic        req_tlast,   // final_column
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // out_char [7:0]
   output logic        rsp_tlast    // run_end
);

   logic          queue_full;
   logic          push_valid;
   aese_cmd_type  push_cmd;
   logic          pop;
   aese_head_type head;

   aese_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   aese_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head       (head)
   );

   aese_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/aese_checker.sv =====
module aese_checker import aese_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // ref_char [7:0], query_char [15:8]
   input  logic        req_tlast,   // final_column
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,   // out_char [7:0]
   input  logic        rsp_tlast    // run_end
);

   logic rsp_xfer;
   logic digit_due_ff, digit_due_in;

   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // Track a run prefix that must be followed by a digit
   always_comb begin
      digit_due_in = digit_due_ff;
      if (rsp_xfer) begin
         digit_due_in = !rsp_tlast &&
                        ((rsp_tdata == INS_CHAR) || (rsp_tdata == SUB_CHAR));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_due_ff <= 1'b0;
      end else begin
         digit_due_ff <= digit_due_in;
      end
   end

   // Stalled column holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("stalled column changed");

   // Stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // Reset leaves the queue ready to accept and the output register empty
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

   // A prefix is always followed by an octal digit, never the run end
   a_digit_after_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && digit_due_ff |->
         !rsp_tlast && (rsp_tdata >= DIGIT0) && (rsp_tdata <= DIGIT0 + 8'd7))
      else $error("missing digit after run prefix");

   // Characters other than the run end are prefixes or digits
   a_inner_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_xfer && !rsp_tlast |->
         (rsp_tdata == INS_CHAR) || (rsp_tdata == SUB_CHAR) ||
         ((rsp_tdata >= DIGIT0) && (rsp_tdata <= DIGIT0 + 8'd7)))
      else $error("unexpected inner character");

endmodule

bind alignment_edit_script_encoder_core aese_checker u_aese_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
